// File: sv/trs_pkg.sv
// Shared types and constants for the triangle raster scan shader.
// Depends on nothing; trs_front, trs_fifo, trs_back and the top level refer to it by scoped names.
`default_nettype none
package trs_pkg;
   localparam int CoordBits = 12;
   localparam int CsrAddrBits = 5;
   localparam logic [2:0] RegV0Pos = 3'd0;
   localparam logic [2:0] RegV1Pos = 3'd1;
   localparam logic [2:0] RegV2Pos = 3'd2;
   localparam logic [2:0] RegV0Col = 3'd3;
   localparam logic [2:0] RegV1Col = 3'd4;
   localparam logic [2:0] RegV2Col = 3'd5;

   typedef struct packed {
      logic [11:0] pixel_x;
      logic [11:0] pixel_y;
      logic        covered;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        last_pixel;
      logic        scan_idle;
   } rsp_type;

   typedef struct packed {
      logic        idle;
      logic        last;
      logic [11:0] x;
      logic [11:0] y;
   } job_type;
endpackage
`default_nettype wire

// File: sv/trs_if.sv
// Valid/ready channel interface carrying one payload.
// Depends on nothing beyond the payload type given as a parameter.
`default_nettype none
interface trs_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/trs_front.sv
// Front part: latches the bounding box and steps the scan counters.
// Depends on trs_pkg; emits one pixel job per accepted tick.
`default_nettype none
module trs_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire logic               start_scan,
   input  wire logic [3*24-1:0]    pos,
   output logic                    job_valid,
   input  wire logic               job_ready,
   output trs_pkg::job_type        job
);
   localparam int COORD_BITS = trs_pkg::CoordBits;

   logic [COORD_BITS-1:0] xs [3];
   logic [COORD_BITS-1:0] ys [3];
   logic [COORD_BITS-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [COORD_BITS-1:0] minx_ff, minx_in, maxx_ff, maxx_in;
   logic [COORD_BITS-1:0] miny_ff, miny_in, maxy_ff, maxy_in;
   logic                  act_ff, act_in;
   logic [COORD_BITS-1:0] cx, cy, bminx, bmaxx, bminy, bmaxy;
   logic                  cact;

   assign in_ready  = job_ready;
   assign job_valid = in_valid;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         xs[k] = pos[24*k +: COORD_BITS];
         ys[k] = pos[24*k + COORD_BITS +: COORD_BITS];
      end
      bminx = xs[0]; bmaxx = xs[0]; bminy = ys[0]; bmaxy = ys[0];
      for (int k = 1; k < 3; k++) begin
         if (xs[k] < bminx) bminx = xs[k];
         if (xs[k] > bmaxx) bmaxx = xs[k];
         if (ys[k] < bminy) bminy = ys[k];
         if (ys[k] > bmaxy) bmaxy = ys[k];
      end
      minx_in = minx_ff; maxx_in = maxx_ff; miny_in = miny_ff; maxy_in = maxy_ff;
      cx = sx_ff; cy = sy_ff; cact = act_ff;
      if (start_scan) begin
         minx_in = bminx; maxx_in = bmaxx; miny_in = bminy; maxy_in = bmaxy;
         cx = bminx; cy = bminy; cact = 1'b1;
      end
      sx_in = cx; sy_in = cy; act_in = cact;
      if (cact) begin
         if (cy >= maxy_in) begin
            sy_in = miny_in;
            if (cx >= maxx_in) act_in = 1'b0;
            else sx_in = cx + 1'b1;
         end else begin
            sy_in = cy + 1'b1;
         end
      end
      job.idle = !cact;
      job.last = cact && (cx >= maxx_in) && (cy >= maxy_in);
      job.x = cact ? 12'(cx) : '0;
      job.y = cact ? 12'(cy) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sx_ff <= '0; sy_ff <= '0; act_ff <= 1'b0;
         minx_ff <= '0; maxx_ff <= '0; miny_ff <= '0; maxy_ff <= '0;
      end else if (in_valid && in_ready) begin
         sx_ff <= sx_in; sy_ff <= sy_in; act_ff <= act_in;
         minx_ff <= minx_in; maxx_ff <= maxx_in;
         miny_ff <= miny_in; maxy_ff <= maxy_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) act_ff |-> sx_ff <= maxx_ff)
      else $error("scan x beyond box");
   assert property (@(posedge clock) disable iff (reset) act_ff |-> sy_ff <= maxy_ff)
      else $error("scan y beyond box");
   assert property (@(posedge clock) disable iff (reset)
      job_valid && job.last |-> !job.idle) else $error("last on idle");
endmodule
`default_nettype wire

// File: sv/trs_fifo.sv
// Two-entry queue between the front and back parts.
// Depends on trs_pkg for the job type.
`default_nettype none
module trs_fifo (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire trs_pkg::job_type in_data,
   output logic              out_valid,
   input  wire logic         out_ready,
   output trs_pkg::job_type  out_data
);
   trs_pkg::job_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic       wr, rd;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data  = mem_ff[rp_ff];
   assign wr = in_valid && in_ready;
   assign rd = out_valid && out_ready;
   assign cnt_in = cnt_ff + {1'b0, wr} - {1'b0, rd};

   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= in_data;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= !wp_ff;
         if (rd) rp_ff <= !rp_ff;
         cnt_ff <= cnt_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count overflow");
endmodule
`default_nettype wire

// File: sv/trs_back.sv
// Back part: edge tests, barycentric weights and a serial divider per pixel.
// Depends on trs_pkg; one job is shaded at a time.
`default_nettype none
module trs_back (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           job_valid,
   output logic                job_ready,
   input  wire trs_pkg::job_type job,
   input  wire logic [3*24-1:0] pos,
   input  wire logic [3*24-1:0] col,
   output logic                out_valid,
   input  wire logic           out_ready,
   output trs_pkg::rsp_type    out_data
);
   localparam int COORD_BITS = trs_pkg::CoordBits;
   localparam int CW = 2*COORD_BITS + 2;
   localparam int SW = CW + 10;
   localparam int QW = SW;
   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StCross = 3'd1;
   localparam logic [2:0] StMul = 3'd2;
   localparam logic [2:0] StDiv = 3'd3;
   localparam logic [2:0] StOut = 3'd4;

   logic [2:0] st_ff, st_in;
   trs_pkg::job_type job_ff;
   logic signed [COORD_BITS+1:0] dx [3], dy [3];
   logic signed [CW-1:0] c_ff [3];
   logic signed [CW-1:0] area_s;
   logic [CW-1:0] area_ff, w [3];
   logic [SW-1:0] sum_ff [3], rem_ff [3], quo_ff [3];
   logic [$clog2(QW+1)-1:0] bit_ff;
   logic [1:0] ch_ff;
   logic cov;
   logic same;
   trs_pkg::rsp_type res_ff;
   logic [SW:0] trial;

   assign same = col[23:0] == col[47:24] && col[23:0] == col[71:48];
   assign cov = (c_ff[0] >= 0 && c_ff[1] >= 0 && c_ff[2] >= 0) ||
                (c_ff[0] <= 0 && c_ff[1] <= 0 && c_ff[2] <= 0);
   assign job_ready = st_ff == StIdle;
   assign out_valid = st_ff == StOut;
   assign out_data  = res_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dx[k] = $signed({2'b0, pos[24*k +: COORD_BITS]})
               - $signed({2'b0, job_ff.x[COORD_BITS-1:0]});
         dy[k] = $signed({2'b0, pos[24*k + COORD_BITS +: COORD_BITS]})
               - $signed({2'b0, job_ff.y[COORD_BITS-1:0]});
      end
      area_s = CW'((dx[0]-dx[1]) * (dy[0]-dy[2])) - CW'((dy[0]-dy[1]) * (dx[0]-dx[2]));
      w[0] = c_ff[1][CW-1] ? CW'(-c_ff[1]) : CW'(c_ff[1]);
      w[1] = c_ff[2][CW-1] ? CW'(-c_ff[2]) : CW'(c_ff[2]);
      w[2] = c_ff[0][CW-1] ? CW'(-c_ff[0]) : CW'(c_ff[0]);
      trial = {rem_ff[ch_ff][SW-2:0], sum_ff[ch_ff][SW-1]} - {1'b0, SW'(area_ff)};
      st_in = st_ff;
      unique case (st_ff)
         StIdle:  if (job_valid) st_in = StCross;
         StCross: st_in = StMul;
         StMul:   st_in = StDiv;
         StDiv:   if (bit_ff == '0 && ch_ff == 2'd2) st_in = StOut;
         StOut:   if (out_ready) st_in = StIdle;
         default: st_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      unique case (st_ff)
         StIdle: job_ff <= job;
         StCross: begin
            for (int k = 0; k < 3; k++)
               c_ff[k] <= CW'(dx[k]*dy[(k+1)%3]) - CW'(dy[k]*dx[(k+1)%3]);
            area_ff <= area_s[CW-1] ? CW'(-area_s) : CW'(area_s);
         end
         StMul: begin
            for (int ch = 0; ch < 3; ch++) begin
               sum_ff[ch] <= SW'(w[0]*col[16-8*ch +: 8]) + SW'(w[1]*col[24+16-8*ch +: 8])
                           + SW'(w[2]*col[48+16-8*ch +: 8]);
               rem_ff[ch] <= '0;
               quo_ff[ch] <= '0;
            end
            bit_ff <= ($clog2(QW+1))'(QW);
            ch_ff <= 2'd0;
         end
         StDiv: begin
            if (bit_ff != '0) begin
               sum_ff[ch_ff] <= {sum_ff[ch_ff][SW-2:0], 1'b0};
               if (!trial[SW]) begin
                  rem_ff[ch_ff] <= trial[SW-1:0];
                  quo_ff[ch_ff] <= {quo_ff[ch_ff][SW-2:0], 1'b1};
               end else begin
                  rem_ff[ch_ff] <= {rem_ff[ch_ff][SW-2:0], sum_ff[ch_ff][SW-1]};
                  quo_ff[ch_ff] <= {quo_ff[ch_ff][SW-2:0], 1'b0};
               end
               bit_ff <= bit_ff - 1'b1;
            end else begin
               ch_ff <= ch_ff + 1'b1;
               bit_ff <= ($clog2(QW+1))'(QW);
            end
         end
         StOut: ;
         default: ;
      endcase
      if (st_ff == StDiv && st_in == StOut) begin
         res_ff.pixel_x <= job_ff.x;
         res_ff.pixel_y <= job_ff.y;
         res_ff.covered <= !job_ff.idle && cov;
         res_ff.last_pixel <= job_ff.last;
         res_ff.scan_idle <= job_ff.idle;
         if (!job_ff.idle && cov && same) begin
            res_ff.red <= col[23:16]; res_ff.green <= col[15:8]; res_ff.blue <= col[7:0];
         end else if (!job_ff.idle && cov && area_ff != '0) begin
            res_ff.red   <= quo_ff[0] > 255 ? 8'hFF : quo_ff[0][7:0];
            res_ff.green <= quo_ff[1] > 255 ? 8'hFF : quo_ff[1][7:0];
            res_ff.blue  <= quo_ff[2] > 255 ? 8'hFF : quo_ff[2][7:0];
         end else begin
            res_ff.red <= '0; res_ff.green <= '0; res_ff.blue <= '0;
         end
      end
      if (reset) st_ff <= StIdle;
      else st_ff <= st_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      out_valid && out_data.scan_idle |-> !out_data.covered) else $error("idle covered");
   assert property (@(posedge clock) disable iff (reset)
      st_ff == StOut && !out_ready |=> st_ff == StOut) else $error("result dropped");
endmodule
`default_nettype wire

// File: sv/triangle_raster_scan_shader.sv
// Top level: register file, front scan stepper, queue and back shading unit.
// Depends on trs_pkg, trs_if, trs_front, trs_fifo and trs_back.
// The back part takes no new pixel until the three serial channel divides of the last one are done.
// The front and queue accept up to two ticks ahead of the back part.
// Reset (synchronous, active high) clears the control state and the register file and goes idle.
`default_nettype none
module triangle_raster_scan_shader (
   input  wire logic        clock,
   input  wire logic        reset,
   trs_if.sink              req,
   trs_if.source            rsp,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [trs_pkg::CsrAddrBits-1:0] csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   logic [23:0] regs_ff [6];
   logic [2:0] idx;
   logic fj_valid, fj_ready, bj_valid, bj_ready;
   trs_pkg::job_type fj, bj;
   logic [3*24-1:0] pos, col;
   trs_pkg::rsp_type rd;

   assign csr_pready = 1'b1;
   assign idx = csr_paddr[4:2];
   assign csr_prdata = (idx <= trs_pkg::RegV2Col) ? {8'h0, regs_ff[idx]} : 32'h0;
   assign pos = {regs_ff[trs_pkg::RegV2Pos], regs_ff[trs_pkg::RegV1Pos],
                 regs_ff[trs_pkg::RegV0Pos]};
   assign col = {regs_ff[trs_pkg::RegV2Col], regs_ff[trs_pkg::RegV1Col],
                 regs_ff[trs_pkg::RegV0Col]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 6; k++) regs_ff[k] <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && idx <= trs_pkg::RegV2Col
                   && csr_paddr[1:0] == 2'b00) begin
         regs_ff[idx] <= csr_pwdata[23:0];
      end
   end

   trs_front u_front (
      .clock, .reset, .in_valid(req.valid), .in_ready(req.ready),
      .start_scan(req.data), .pos, .job_valid(fj_valid), .job_ready(fj_ready), .job(fj));

   trs_fifo u_fifo (
      .clock, .reset, .in_valid(fj_valid), .in_ready(fj_ready), .in_data(fj),
      .out_valid(bj_valid), .out_ready(bj_ready), .out_data(bj));

   trs_back u_back (
      .clock, .reset, .job_valid(bj_valid), .job_ready(bj_ready), .job(bj), .pos, .col,
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rd));

   assign rsp.data = rd;
endmodule
`default_nettype wire
